// ----- hdl/ihex_pkg.sv -----
// Package for the Intel HEX stream decoder.
// Holds the transaction types, record and status codes, parser phases and the hex digit decoder.
// No dependencies.
`timescale 1ns / 1ps

package ihex_pkg;

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic        kind;
        logic [32:0] byte_address;
        logic [7:0]  byte_value;
        logic [3:0]  status;
        logic [32:0] image_low;
        logic [32:0] image_high;
    } out_t;

    typedef enum logic [4:0] {
        PH_WAIT   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_DATA   = 5'b00100,
        PH_CHECK  = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_ESA  = 8'h02;
    localparam logic [7:0] REC_ELA  = 8'h04;

    localparam logic [7:0] EXT_LENGTH = 8'd2;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_BAD_HEADER = 4'd1;
    localparam logic [3:0] ST_TRUNC_DATA = 4'd2;
    localparam logic [3:0] ST_NO_CHECK   = 4'd3;
    localparam logic [3:0] ST_CHECKSUM   = 4'd4;
    localparam logic [3:0] ST_BAD_ELA    = 4'd5;
    localparam logic [3:0] ST_BAD_ESA    = 4'd6;
    localparam logic [3:0] ST_NO_DATA    = 4'd7;
    localparam logic [3:0] ST_NO_EOF     = 4'd8;

    localparam logic [32:0] ADDR_ALL_ONES = {33{1'b1}};

    // Returns the digit valid flag in bit 4 and the nibble in bits 3..0.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic [3:0] phase_error(input phase_t ph);
        logic [3:0] r;
        case (ph)
            PH_HEADER: r = ST_BAD_HEADER;
            PH_DATA:   r = ST_TRUNC_DATA;
            default:   r = ST_NO_CHECK;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/ihex_in_stage.sv -----
// Input register of the Intel HEX stream decoder.
// Holds one character transaction until the parser takes it; uses ihex_pkg.
`timescale 1ns / 1ps

module ihex_in_stage (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         char_valid,
    output logic         char_ready,
    input  ihex_pkg::in_t char_data,
    input  logic         take,
    output logic         item_valid,
    output ihex_pkg::in_t item
);
    import ihex_pkg::*;

    logic valid_reg;
    logic valid_next;
    in_t  data_reg;

    assign char_ready = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (char_valid && char_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
        begin
            data_reg <= char_data;
        end
    end

endmodule

// ----- hdl/ihex_out_stage.sv -----
// Result register of the Intel HEX stream decoder.
// Holds one result transaction until the consumer takes it; uses ihex_pkg.
`timescale 1ns / 1ps

module ihex_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  ihex_pkg::out_t load_data,
    output logic          space,
    output logic          res_valid,
    input  logic          res_ready,
    output ihex_pkg::out_t res_data
);
    import ihex_pkg::*;

    logic valid_reg;
    logic valid_next;
    out_t data_reg;

    assign space     = !valid_reg || res_ready;
    assign res_valid = valid_reg;
    assign res_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

// ----- hdl/ihex_parser.sv -----
// Record parser of the Intel HEX stream decoder.
// Decodes a character per cycle while space is high; tracks record state, base address, image bounds; uses ihex_pkg.
`timescale 1ns / 1ps

module ihex_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  ihex_pkg::in_t  item,
    input  logic          space,
    output logic          take,
    output logic          result_valid,
    output ihex_pkg::out_t result
);
    import ihex_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        nib_valid_reg, nib_valid_next;
    logic [3:0]  nib_reg, nib_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  off_hi_reg, off_hi_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [15:0] ext_reg, ext_next;
    logic [31:0] base_reg, base_next;
    logic        seen_reg, seen_next;
    logic [32:0] low_reg, low_next;
    logic [32:0] high_reg, high_next;
    logic [32:0] rec_addr_reg, rec_addr_next;
    logic [32:0] rec_end_reg, rec_end_next;
    logic [32:0] dat_addr_reg, dat_addr_next;

    logic [4:0]  digit;
    logic [7:0]  byte_val;
    logic [7:0]  sum_plus;
    logic        summary;
    logic        data_out;
    logic [3:0]  status;

    assign take     = item_valid && space;
    assign digit    = hex_digit(item.text_char);
    assign byte_val = {nib_reg, digit[3:0]};
    assign sum_plus = sum_reg + byte_val;

    always_comb
    begin
        phase_next     = phase_reg;
        nib_valid_next = nib_valid_reg;
        nib_next       = nib_reg;
        len_next       = len_reg;
        off_hi_next    = off_hi_reg;
        type_next      = type_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        ext_next       = ext_reg;
        base_next      = base_reg;
        seen_next      = seen_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        rec_addr_next  = rec_addr_reg;
        rec_end_next   = rec_end_reg;
        dat_addr_next  = dat_addr_reg;
        summary        = 1'b0;
        data_out       = 1'b0;
        status         = ST_OK;

        if (phase_reg == PH_WAIT)
        begin
            if (item.text_char == CHAR_COLON)
            begin
                phase_next     = PH_HEADER;
                nib_valid_next = 1'b0;
                len_next       = 8'd0;
                off_hi_next    = 8'd0;
                type_next      = REC_DATA;
                sum_next       = 8'd0;
                cnt_next       = 8'd0;
                ext_next       = 16'd0;
            end
        end
        else if (phase_reg != PH_DONE)
        begin
            if (!digit[4])
            begin
                status     = phase_error(phase_reg);
                summary    = 1'b1;
                phase_next = PH_DONE;
            end
            else if (!nib_valid_reg)
            begin
                nib_valid_next = 1'b1;
                nib_next       = digit[3:0];
            end
            else
            begin
                nib_valid_next = 1'b0;
                case (phase_reg)
                    PH_HEADER:
                    begin
                        sum_next = sum_plus;
                        cnt_next = cnt_reg + 8'd1;
                        case (cnt_reg[1:0])
                            2'd0: len_next = byte_val;
                            2'd1: off_hi_next = byte_val;
                            2'd2:
                            begin
                                rec_addr_next = {1'b0, base_reg} + {17'd0, off_hi_reg, byte_val};
                                dat_addr_next = rec_addr_next;
                            end
                            default:
                            begin
                                type_next    = byte_val;
                                rec_end_next = rec_addr_reg + {25'd0, len_reg};
                                cnt_next     = 8'd0;
                                phase_next   = (len_reg != 8'd0) ? PH_DATA : PH_CHECK;
                            end
                        endcase
                    end
                    PH_DATA:
                    begin
                        sum_next      = sum_plus;
                        ext_next      = {ext_reg[7:0], byte_val};
                        data_out      = (type_reg == REC_DATA);
                        dat_addr_next = dat_addr_reg + 33'd1;
                        cnt_next      = cnt_reg + 8'd1;
                        if (cnt_next == len_reg)
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_WAIT;
                        if (sum_plus != 8'd0)
                        begin
                            status     = ST_CHECKSUM;
                            summary    = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else if (type_reg == REC_DATA)
                        begin
                            if (rec_addr_reg < low_reg)
                            begin
                                low_next = rec_addr_reg;
                            end
                            if (rec_end_reg > high_reg)
                            begin
                                high_next = rec_end_reg;
                            end
                            seen_next = 1'b1;
                        end
                        else if (type_reg == REC_ELA)
                        begin
                            if (len_reg != EXT_LENGTH)
                            begin
                                status     = ST_BAD_ELA;
                                summary    = 1'b1;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                base_next = {ext_reg, 16'd0};
                            end
                        end
                        else if (type_reg == REC_ESA)
                        begin
                            if (len_reg != EXT_LENGTH)
                            begin
                                status     = ST_BAD_ESA;
                                summary    = 1'b1;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                base_next = {12'd0, ext_reg, 4'd0};
                            end
                        end
                        else if (type_reg == REC_EOF)
                        begin
                            status     = seen_reg ? ST_OK : ST_NO_DATA;
                            summary    = 1'b1;
                            phase_next = PH_DONE;
                        end
                    end
                endcase
            end
        end

        if (item.end_of_text && !summary && phase_next != PH_DONE)
        begin
            if (phase_next == PH_WAIT)
            begin
                status = seen_next ? ST_NO_EOF : ST_NO_DATA;
            end
            else
            begin
                status = phase_error(phase_next);
            end
            summary = 1'b1;
        end
    end

    always_comb
    begin
        result       = '0;
        result_valid = summary || data_out;
        if (summary)
        begin
            result.kind       = KIND_SUMMARY;
            result.status     = status;
            result.image_low  = low_next;
            result.image_high = high_next;
        end
        else
        begin
            result.kind         = KIND_DATA;
            result.byte_address = dat_addr_reg;
            result.byte_value   = byte_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            nib_valid_reg <= 1'b0;
            nib_reg       <= 4'd0;
            len_reg       <= 8'd0;
            off_hi_reg    <= 8'd0;
            type_reg      <= REC_DATA;
            sum_reg       <= 8'd0;
            cnt_reg       <= 8'd0;
            ext_reg       <= 16'd0;
            base_reg      <= 32'd0;
            seen_reg      <= 1'b0;
            low_reg       <= ADDR_ALL_ONES;
            high_reg      <= 33'd0;
        end
        else if (take)
        begin
            if (item.end_of_text)
            begin
                phase_reg     <= PH_WAIT;
                nib_valid_reg <= 1'b0;
                nib_reg       <= 4'd0;
                len_reg       <= 8'd0;
                off_hi_reg    <= 8'd0;
                type_reg      <= REC_DATA;
                sum_reg       <= 8'd0;
                cnt_reg       <= 8'd0;
                ext_reg       <= 16'd0;
                base_reg      <= 32'd0;
                seen_reg      <= 1'b0;
                low_reg       <= ADDR_ALL_ONES;
                high_reg      <= 33'd0;
            end
            else
            begin
                phase_reg     <= phase_next;
                nib_valid_reg <= nib_valid_next;
                nib_reg       <= nib_next;
                len_reg       <= len_next;
                off_hi_reg    <= off_hi_next;
                type_reg      <= type_next;
                sum_reg       <= sum_next;
                cnt_reg       <= cnt_next;
                ext_reg       <= ext_next;
                base_reg      <= base_next;
                seen_reg      <= seen_next;
                low_reg       <= low_next;
                high_reg      <= high_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rec_addr_reg <= rec_addr_next;
            rec_end_reg  <= rec_end_next;
            dat_addr_reg <= dat_addr_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_eot_resets: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.end_of_text |=> phase_reg == PH_WAIT && !seen_reg && !nib_valid_reg)
        else $error("parser state not cleared after end of text");

    a_data_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        take && result_valid && result.kind == KIND_DATA |-> phase_reg == PH_DATA)
        else $error("data byte produced outside the data field");

    a_wait_summary_needs_eot: assert property (@(posedge clk) disable iff (!rst_n)
        take && summary && phase_reg == PH_WAIT |-> item.end_of_text)
        else $error("summary between records without end of text");

    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> low_reg <= high_reg)
        else $error("image bounds out of order");
`endif

endmodule

// ----- hdl/intel_hex_stream_decoder.sv -----
// Intel HEX stream decoder: takes one text character per transaction and returns decoded
// data bytes with absolute addresses and one summary per stream. An item can be taken every
// cycle while the result register has space. A result is offered once its character has
// passed the input register and the result register, and char_ready follows res_ready
// within the same cycle.
// Depends on ihex_pkg, ihex_in_stage, ihex_parser and ihex_out_stage.
`timescale 1ns / 1ps

module intel_hex_stream_decoder (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          char_valid,
    output logic          char_ready,
    input  ihex_pkg::in_t  char_data,
    output logic          res_valid,
    input  logic          res_ready,
    output ihex_pkg::out_t res_data
);
    import ihex_pkg::*;

    logic item_valid;
    in_t  item;
    logic take;
    logic space;
    logic result_valid;
    out_t result;

    ihex_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    ihex_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .space        (space),
        .take         (take),
        .result_valid (result_valid),
        .result       (result)
    );

    ihex_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && result_valid),
        .load_data (result),
        .space     (space),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule
